FILE: sv/incscan_pkg.sv
// Package for the include-line scanner: offset width, phase and break codes,
// payload types and small helper functions. No dependencies.
package incscan_pkg;

  localparam int OFFSET_BITS = 16;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [7:0]             byte_t;
  typedef logic [15:0]            field16_t;
  typedef logic [3:0]             phase_t;
  typedef logic [2:0]             kw_index_t;
  typedef logic [1:0]             brk_t;

  localparam offset_t COUNT_MAX = {OFFSET_BITS{1'b1}};

  // Scan phases.
  localparam phase_t PH_LEAD      = 4'd0;
  localparam phase_t PH_HASH_WS   = 4'd1;
  localparam phase_t PH_KEYWORD   = 4'd2;
  localparam phase_t PH_PRE_QUOTE = 4'd3;
  localparam phase_t PH_NAME      = 4'd4;
  localparam phase_t PH_TAIL      = 4'd5;
  localparam phase_t PH_SKIP      = 4'd6;

  // Pending break kinds.
  localparam brk_t BRK_NONE = 2'd0;
  localparam brk_t BRK_CR   = 2'd1;
  localparam brk_t BRK_LF   = 2'd2;

  localparam kw_index_t KW_LEN = 3'd7;

  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_HASH  = 8'h23;
  localparam byte_t CH_QUOTE = 8'h22;

  // Letters of the keyword "include".
  function automatic byte_t kw_char(input kw_index_t idx);
    byte_t c;
    case (idx)
      3'd0:    c = 8'h69; // i
      3'd1:    c = 8'h6E; // n
      3'd2:    c = 8'h63; // c
      3'd3:    c = 8'h6C; // l
      3'd4:    c = 8'h75; // u
      3'd5:    c = 8'h64; // d
      3'd6:    c = 8'h65; // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic offset_t sat_inc(input offset_t v);
    offset_t r;
    r = (v == COUNT_MAX) ? COUNT_MAX : v + offset_t'(1);
    return r;
  endfunction

  function automatic logic is_blank(input byte_t b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  // Low 16 bits of an offset, zero-extended when offsets are narrower.
  function automatic field16_t to_field(input offset_t v);
    logic [OFFSET_BITS+15:0] wide;
    wide = {16'b0, v};
    return wide[15:0];
  endfunction

endpackage

FILE: sv/incscan_in_if.sv
// Request channel carrying one text byte or an end mark.
// Depends on incscan_pkg.
interface incscan_in_if;
  logic                  valid;
  logic                  ready;
  incscan_pkg::byte_t    text_byte;
  logic                  end_mark;

  modport source (output valid, output text_byte, output end_mark, input ready);
  modport sink   (input valid, input text_byte, input end_mark, output ready);
endinterface

FILE: sv/incscan_out_if.sv
// Result channel carrying one include-line record.
// Depends on incscan_pkg.
interface incscan_out_if;
  logic                  valid;
  logic                  ready;
  incscan_pkg::field16_t line_begin;
  incscan_pkg::field16_t line_finish;
  incscan_pkg::field16_t name_begin;
  incscan_pkg::field16_t name_length;
  incscan_pkg::field16_t following_line;

  modport source (output valid, output line_begin, output line_finish, output name_begin,
                  output name_length, output following_line, input ready);
  modport sink   (input valid, input line_begin, input line_finish, input name_begin,
                  input name_length, input following_line, output ready);
endinterface

FILE: sv/include_directive_scanner_core.sv
// Include-line scanner: per-byte state machine with a registered result.
// Depends on incscan_pkg, incscan_in_if and incscan_out_if.
// A record is registered and appears on out_chan in the cycle after the break or end request is accepted.
// Throughput: one request per cycle while in_chan is ready; the per-byte phase update is combinational.
// in_chan is ready whenever the result register is empty or being drained.
// Reset (rst_n low, synchronous) returns the scanner to line start, line 1, offset 0.
module include_directive_scanner_core (
  input  logic           clk,
  input  logic           rst_n,
  incscan_in_if.sink     in_chan,
  incscan_out_if.source  out_chan
);
  import incscan_pkg::*;

  // Scanner state.
  phase_t    phase_r, phase_nxt;
  kw_index_t kw_idx_r, kw_idx_nxt;
  offset_t   pos_r, pos_nxt;
  offset_t   line_r, line_nxt;
  offset_t   line_start_r, line_start_nxt;
  offset_t   name_start_r, name_start_nxt;
  offset_t   name_cnt_r, name_cnt_nxt;
  brk_t      brk_r, brk_nxt;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  field16_t  line_begin_r, line_finish_r, name_begin_r, name_length_r, following_r;

  logic      in_fire;
  logic      produce;
  offset_t   pos_inc;
  byte_t     b;
  logic      is_break;
  logic      pair;

  // Accept while the result register is free or being taken this cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign b        = in_chan.text_byte;
  assign pos_inc  = sat_inc(pos_r);
  assign is_break = (b == CH_CR) || (b == CH_LF);
  assign pair     = ((brk_r == BRK_CR) && (b == CH_LF)) ||
                    ((brk_r == BRK_LF) && (b == CH_CR));

  // A record leaves only from the tail phase, on a break byte or on end of text.
  // A break byte that closes a CR LF / LF CR pair is swallowed first.
  assign produce = in_fire && (phase_r == PH_TAIL) &&
                   (in_chan.end_mark || (is_break && !pair));

  always_comb begin
    phase_nxt      = phase_r;
    kw_idx_nxt     = kw_idx_r;
    pos_nxt        = pos_r;
    line_nxt       = line_r;
    line_start_nxt = line_start_r;
    name_start_nxt = name_start_r;
    name_cnt_nxt   = name_cnt_r;
    brk_nxt        = brk_r;

    if (in_fire) begin
      if (in_chan.end_mark) begin
        // End of text: drop everything back to the reset state.
        phase_nxt      = PH_LEAD;
        kw_idx_nxt     = '0;
        pos_nxt        = '0;
        line_nxt       = offset_t'(1);
        line_start_nxt = '0;
        name_start_nxt = '0;
        name_cnt_nxt   = '0;
        brk_nxt        = BRK_NONE;
      end else begin
        pos_nxt = pos_inc;
        brk_nxt = BRK_NONE;
        if (pair) begin
          // Second half of a two-byte break: just move the line start.
          line_start_nxt = pos_inc;
        end else if (is_break) begin
          line_nxt       = sat_inc(line_r);
          brk_nxt        = (b == CH_CR) ? BRK_CR : BRK_LF;
          phase_nxt      = PH_LEAD;
          kw_idx_nxt     = '0;
          line_start_nxt = pos_inc;
        end else begin
          case (phase_r)
            PH_LEAD: begin
              if (b == CH_HASH) begin
                phase_nxt = PH_HASH_WS;
              end else if (!is_blank(b)) begin
                phase_nxt = PH_SKIP;
              end
            end
            PH_HASH_WS: begin
              if (b == kw_char('0)) begin
                kw_idx_nxt = 3'd1;
                phase_nxt  = PH_KEYWORD;
              end else if (!is_blank(b)) begin
                phase_nxt = PH_SKIP;
              end
            end
            PH_KEYWORD: begin
              if (kw_idx_r < KW_LEN) begin
                if (b == kw_char(kw_idx_r)) begin
                  kw_idx_nxt = kw_idx_r + 3'd1;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end else begin
                // Keyword complete: at least one blank must follow.
                phase_nxt = is_blank(b) ? PH_PRE_QUOTE : PH_SKIP;
              end
            end
            PH_PRE_QUOTE: begin
              if (b == CH_QUOTE) begin
                name_start_nxt = pos_inc;
                name_cnt_nxt   = '0;
                phase_nxt      = PH_NAME;
              end else if (!is_blank(b)) begin
                phase_nxt = PH_SKIP;
              end
            end
            PH_NAME: begin
              if (b == CH_QUOTE) begin
                phase_nxt = PH_TAIL;
              end else begin
                name_cnt_nxt = sat_inc(name_cnt_r);
              end
            end
            PH_TAIL: begin
              phase_nxt = PH_TAIL;
            end
            default: begin
              phase_nxt = PH_SKIP;
            end
          endcase
        end
      end
    end
  end

  // Hold a result until taken; load a new one when produced.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      kw_idx_r     <= '0;
      pos_r        <= '0;
      line_r       <= offset_t'(1);
      line_start_r <= '0;
      name_start_r <= '0;
      name_cnt_r   <= '0;
      brk_r        <= BRK_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      kw_idx_r     <= kw_idx_nxt;
      pos_r        <= pos_nxt;
      line_r       <= line_nxt;
      line_start_r <= line_start_nxt;
      name_start_r <= name_start_nxt;
      name_cnt_r   <= name_cnt_nxt;
      brk_r        <= brk_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload: line finish is the current offset for both a break and end of text.
  always_ff @(posedge clk) begin
    if (produce) begin
      line_begin_r  <= to_field(line_start_r);
      line_finish_r <= to_field(pos_r);
      name_begin_r  <= to_field(name_start_r);
      name_length_r <= to_field(name_cnt_r);
      following_r   <= to_field(sat_inc(line_r));
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.line_begin     = line_begin_r;
  assign out_chan.line_finish    = line_finish_r;
  assign out_chan.name_begin     = name_begin_r;
  assign out_chan.name_length    = name_length_r;
  assign out_chan.following_line = following_r;

  // End of text must leave the scanner at its start state.
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.end_mark) |=>
      (pos_r == '0) && (line_r == offset_t'(1)) && (phase_r == PH_LEAD) && (brk_r == BRK_NONE))
    else $error("scanner state not cleared after end of text");

  // A record must be registered right after it is produced.
  a_produce_shows: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> out_valid_r)
    else $error("produced record not presented");

  // No record may appear unless the scanner was in the tail phase.
  a_only_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (phase_r != PH_TAIL) && !(out_valid_r && !out_chan.ready)) |=> !out_valid_r)
    else $error("record produced outside tail phase");

  // Line start and name length never run ahead of the byte offset.
  a_offsets_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (line_start_r <= pos_r) && (name_cnt_r <= pos_r))
    else $error("offset beyond byte position");

  // Keyword index is never zero in the keyword phase.
  a_kw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KEYWORD) |-> (kw_idx_r != '0))
    else $error("keyword phase with empty keyword index");

endmodule

FILE: sim/incscan_tb_pkg.sv
// Scoreboard package for the include-line scanner testbench: record type and a
// byte-level predictor that queues expected records in order. Depends on incscan_pkg.
package incscan_tb_pkg;
  import incscan_pkg::*;

  typedef struct packed {
    field16_t line_begin;
    field16_t line_finish;
    field16_t name_begin;
    field16_t name_length;
    field16_t following_line;
  } include_rec_t;

  // Keyword letters, first letter in the top byte.
  localparam logic [55:0] KEYWORD      = "include";
  localparam int          REPORT_LIMIT = 10;

  function automatic byte_t keyword_letter(input int idx);
    return KEYWORD[55 - 8*idx -: 8];
  endfunction

  class include_record_board;
    phase_t       scan_phase;
    int           kw_pos;
    offset_t      byte_pos;
    offset_t      line_no;
    offset_t      line_start;
    offset_t      name_start;
    offset_t      name_count;
    brk_t         break_kind;
    include_rec_t expected_records[$];
    int           fail_count;
    int           records_checked;

    function new();
      fail_count      = 0;
      records_checked = 0;
      restart();
    endfunction

    function void restart();
      scan_phase = PH_LEAD;
      kw_pos     = 0;
      byte_pos   = '0;
      line_no    = offset_t'(1);
      line_start = '0;
      name_start = '0;
      name_count = '0;
      break_kind = BRK_NONE;
    endfunction

    function offset_t bump(input offset_t v);
      return (v == COUNT_MAX) ? v : v + offset_t'(1);
    endfunction

    function bit blank(input byte_t b);
      return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function include_rec_t record_at(input offset_t finish);
      include_rec_t r;
      r.line_begin     = field16_t'(line_start);
      r.line_finish    = field16_t'(finish);
      r.name_begin     = field16_t'(name_start);
      r.name_length    = field16_t'(name_count);
      r.following_line = field16_t'(bump(line_no));
      return r;
    endfunction

    function string show(input include_rec_t r);
      return $sformatf("line %0d..%0d name at %0d len %0d next line %0d",
                       r.line_begin, r.line_finish, r.name_begin, r.name_length,
                       r.following_line);
    endfunction

    // Advance the scanner by one request; returns 1 when a record falls out.
    function bit scan_byte(input byte_t b, input logic em, output include_rec_t rec);
      offset_t here;
      bit      paired;
      bit      hit;
      here = byte_pos;
      hit  = 1'b0;
      rec  = '0;
      if (em) begin
        if (scan_phase == PH_TAIL) begin
          rec = record_at(here);
          hit = 1'b1;
        end
        restart();
        return hit;
      end
      byte_pos = bump(here);
      if (break_kind != BRK_NONE) begin
        paired = (break_kind == BRK_CR && b == CH_LF) || (break_kind == BRK_LF && b == CH_CR);
        break_kind = BRK_NONE;
        if (paired) begin
          line_start = bump(here);
          return 1'b0;
        end
      end
      if (b == CH_CR || b == CH_LF) begin
        if (scan_phase == PH_TAIL) begin
          rec = record_at(here);
          hit = 1'b1;
        end
        line_no    = bump(line_no);
        break_kind = (b == CH_CR) ? BRK_CR : BRK_LF;
        scan_phase = PH_LEAD;
        kw_pos     = 0;
        line_start = bump(here);
        return hit;
      end
      case (scan_phase)
        PH_LEAD: begin
          if (b == CH_HASH) scan_phase = PH_HASH_WS;
          else if (!blank(b)) scan_phase = PH_SKIP;
        end
        PH_HASH_WS: begin
          if (b == keyword_letter(0)) begin
            kw_pos     = 1;
            scan_phase = PH_KEYWORD;
          end else if (!blank(b)) begin
            scan_phase = PH_SKIP;
          end
        end
        PH_KEYWORD: begin
          if (kw_pos < int'(KW_LEN)) begin
            if (b == keyword_letter(kw_pos)) kw_pos++;
            else scan_phase = PH_SKIP;
          end else begin
            scan_phase = blank(b) ? PH_PRE_QUOTE : PH_SKIP;
          end
        end
        PH_PRE_QUOTE: begin
          if (b == CH_QUOTE) begin
            name_start = bump(here);
            name_count = '0;
            scan_phase = PH_NAME;
          end else if (!blank(b)) begin
            scan_phase = PH_SKIP;
          end
        end
        PH_NAME: begin
          if (b == CH_QUOTE) scan_phase = PH_TAIL;
          else name_count = bump(name_count);
        end
        PH_TAIL: ;
        default: scan_phase = PH_SKIP;
      endcase
      return 1'b0;
    endfunction

    function void report(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    // Note an accepted request and queue the record it causes, if any.
    function void note_request(input byte_t b, input logic em);
      include_rec_t rec;
      if (scan_byte(b, em, rec)) expected_records.push_back(rec);
    endfunction

    // Compare an accepted record with the oldest one waiting.
    function void check_record(input include_rec_t got);
      include_rec_t want;
      if (expected_records.size() == 0) begin
        report($sformatf("record with none waiting: %s", show(got)));
        return;
      end
      want = expected_records.pop_front();
      if (got.line_begin != want.line_begin || got.line_finish != want.line_finish ||
          got.name_begin != want.name_begin || got.name_length != want.name_length ||
          got.following_line != want.following_line) begin
        report($sformatf("record %0d expected %s, got %s", records_checked, show(want),
                         show(got)));
      end
      records_checked++;
    endfunction

    function int waiting();
      return expected_records.size();
    endfunction

    function bit clean();
      if (expected_records.size() != 0)
        report($sformatf("%0d records never arrived", expected_records.size()));
      return fail_count == 0;
    endfunction
  endclass

endpackage

FILE: sim/tb_include_directive_scanner_core.sv
// Testbench top for include_directive_scanner_core: streams text bytes and end marks,
// predicts include records and checks them in order. Depends on incscan_pkg,
// incscan_in_if, incscan_out_if and incscan_tb_pkg.
module tb_include_directive_scanner_core;
  timeunit 1ns;
  timeprecision 1ps;

  import incscan_pkg::*;
  import incscan_tb_pkg::*;

  localparam int CLK_PERIOD        = 10;
  localparam int RESET_CYCLES      = 4;
  localparam int IDLE_PHASE_ITEMS  = 1500;  // request count up to which idling is on
  localparam int RANDOM_ITEMS      = 1700;  // request count up to which random lines run
  localparam int PRESSURE_LINES    = 8;
  localparam int LONG_HOLD         = 64;    // receiver hold-off for the pressure test
  localparam int DRAIN_CYCLES      = 8;     // settling wait after the last record is checked
  localparam int QUIET_LIMIT       = 2000;  // cycles with no handshake before giving up

  logic clk = 1'b0;
  logic rst_n;

  bit                  idle_on       = 1'b1;
  bit                  hold_results  = 1'b0;
  int                  requests_sent = 0;
  byte_t               line_buf[$];
  include_record_board board         = new();

  incscan_in_if  in_chan();
  incscan_out_if out_chan();

  include_directive_scanner_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until accepted. Entered and left on a rising
  // edge, so valid is written once per edge and stays high between back-to-back
  // requests.
  task automatic offer_byte(input byte_t b, input logic em);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.text_byte <= b;
    in_chan.end_mark  <= em;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    board.note_request(b, em);
    requests_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_byte(byte_t'(s[i]), 1'b0);
  endtask

  // Name bytes: anything but a quote or a break.
  function automatic byte_t pick_plain();
    byte_t b;
    do b = byte_t'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF || b == CH_QUOTE);
    return b;
  endfunction

  function automatic byte_t pick_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  // Fill line_buf with one line, without its break. With well_formed set every
  // line is a well-formed include directive with random spacing, name and tail;
  // otherwise half are, and the rest are broken directives, bare keywords,
  // noise, empty lines and names that never close.
  function automatic void build_line(input bit well_formed);
    int kind;
    line_buf.delete();
    kind = well_formed ? $urandom_range(0, 4) : $urandom_range(0, 9);
    if (kind == 8) return;
    if (kind == 7) begin
      repeat ($urandom_range(1, 10)) line_buf.push_back(byte_t'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 3)) line_buf.push_back(pick_blank());
    line_buf.push_back(CH_HASH);
    repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
    for (int i = 0; i < int'(KW_LEN); i++) line_buf.push_back(keyword_letter(i));
    // keyword right before the break
    if (kind == 6) return;
    // a broken line may also lose the blank after the keyword
    if (kind != 5 || $urandom_range(0, 1)) line_buf.push_back(pick_blank());
    repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
    line_buf.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 6)) line_buf.push_back(pick_plain());
    // name left open
    if (kind == 9) return;
    line_buf.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 4)) line_buf.push_back(byte_t'($urandom_range(0, 255)));
    if (kind == 5)
      line_buf[$urandom_range(0, line_buf.size() - 1)] = byte_t'($urandom_range(0, 255));
  endfunction

  task automatic send_line();
    foreach (line_buf[i]) offer_byte(line_buf[i], 1'b0);
  endtask

  // Close a line with a single break, a break pair, a doubled break or an end mark.
  task automatic end_line();
    case ($urandom_range(0, 7))
      0: offer_byte(CH_CR, 1'b0);
      1: begin
        offer_byte(CH_CR, 1'b0);
        offer_byte(CH_LF, 1'b0);
      end
      2: begin
        offer_byte(CH_LF, 1'b0);
        offer_byte(CH_CR, 1'b0);
      end
      3: begin
        offer_byte(CH_CR, 1'b0);
        offer_byte(CH_CR, 1'b0);
      end
      4: begin
        offer_byte(CH_LF, 1'b0);
        offer_byte(CH_LF, 1'b0);
      end
      5: offer_byte(byte_t'($urandom_range(0, 255)), 1'b1);
      default: offer_byte(CH_LF, 1'b0);
    endcase
  endtask

  task automatic random_lines(input int upto);
    while (requests_sent < upto) begin
      build_line(1'b0);
      send_line();
      end_line();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.text_byte <= '0;
    in_chan.end_mark  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tabs around the hash and keyword, empty name flushed by an end
    // mark whose byte is ignored, extreme byte values, a LF CR pair, a CR CR
    // double break, then the bare keyword cut by a break.
    send_text("\t#\tinclude\t\"\"");
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(CH_LF, 1'b0);
    offer_byte(CH_CR, 1'b0);
    offer_byte(CH_CR, 1'b0);
    offer_byte(CH_CR, 1'b0);
    send_text("#include");
    offer_byte(CH_LF, 1'b0);

    // Pressure: ask the receiver for a long hold-off and keep offering good
    // lines so the result register fills and the input stalls.
    hold_results = 1'b1;
    repeat (PRESSURE_LINES) begin
      build_line(1'b1);
      send_line();
      offer_byte(CH_LF, 1'b0);
    end

    random_lines(IDLE_PHASE_ITEMS);
    idle_on = 1'b0;
    random_lines(RANDOM_ITEMS);

    // Flush whatever line is still open with a final end mark.
    offer_byte(8'h00, 1'b1);
    in_chan.valid <= 1'b0;

    // Drain: wait for every queued record, then allow for the result latency.
    while (board.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.clean()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: check accepted records and pace out_chan.ready.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int           hold_left;
    include_rec_t got;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got.line_begin     = out_chan.line_begin;
        got.line_finish    = out_chan.line_finish;
        got.name_begin     = out_chan.name_begin;
        got.name_length    = out_chan.name_length;
        got.following_line = out_chan.following_line;
        board.check_record(got);
      end
      if (hold_left > 0) begin
        // keep holding the current burst
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_results) begin
        // long hold-off, counted here while the sender keeps going
        hold_results = 1'b0;
        hold_left    = LONG_HOLD - 1;
        out_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: give up after a long stretch with no handshake on either side.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
